// ===== hw/rtl/piqh_pkg.sv =====
// ----------------------------------------------------------------------------
// piqh_pkg: shared types and constants of the palette indexer
// Table geometry, palette geometry, payload structs and the home-slot hash.
// ----------------------------------------------------------------------------
package piqh_pkg;

    localparam int TABLE_SIZE    = 1024;
    localparam int SLOT_W        = $clog2(TABLE_SIZE);
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_W         = $clog2(PALETTE_DEPTH);
    localparam int COLOR_W       = 16;
    localparam int INDEX_W       = 8;
    localparam int PROBE_W       = 11;

    localparam logic [COLOR_W-1:0] TRANSPARENT_COLOR = 16'h7fff;

    // palette limits for the two modes, capped at the palette depth
    localparam int LIMIT_SMALL = (16 < PALETTE_DEPTH) ? 16 : PALETTE_DEPTH;
    localparam int LIMIT_LARGE = (256 < PALETTE_DEPTH) ? 256 : PALETTE_DEPTH;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               is_transparent;
        logic               frame_start;
    } t_pixel;

    typedef struct packed {
        logic [INDEX_W-1:0] palette_index;
        logic               new_entry;
        logic               overflow;
        logic [PROBE_W-1:0] probe_count;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [PAL_W-1:0] idx;
    } t_slot;

    // home slot: red ^ (green << 3) ^ rotate-style spread of blue
    function automatic logic [SLOT_W-1:0] home_slot(input logic [COLOR_W-1:0] c);
        logic [15:0] h;
        h = {11'b0, c[14:10]}
          ^ {8'b0, c[9:5], 3'b0}
          ^ {5'b0, c[4:0], 6'b0}
          ^ {14'b0, c[4:3]};
        return h[SLOT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/piqh_pixel_if.sv =====
// ----------------------------------------------------------------------------
// piqh_pixel_if: pixel channel
// Valid/ready channel carrying one pixel colour and its flags.
// ----------------------------------------------------------------------------
interface piqh_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [piqh_pkg::COLOR_W-1:0]  pixel_color;
    logic                          is_transparent;
    logic                          frame_start;

    modport source (output valid, pixel_color, is_transparent, frame_start, input ready);
    modport sink   (input valid, pixel_color, is_transparent, frame_start, output ready);
endinterface

// ===== hw/rtl/piqh_result_if.sv =====
// ----------------------------------------------------------------------------
// piqh_result_if: result channel
// Valid/ready channel carrying the palette index and status of one pixel.
// ----------------------------------------------------------------------------
interface piqh_result_if;
    logic                          valid;
    logic                          ready;
    logic [piqh_pkg::INDEX_W-1:0]  palette_index;
    logic                          new_entry;
    logic                          overflow;
    logic [piqh_pkg::PROBE_W-1:0]  probe_count;

    modport source (output valid, palette_index, new_entry, overflow, probe_count, input ready);
    modport sink   (input valid, palette_index, new_entry, overflow, probe_count, output ready);
endinterface

// ===== hw/rtl/piqh_probe_engine.sv =====
// ----------------------------------------------------------------------------
// piqh_probe_engine: hash table probe sequencer
// Holds the slot table and the palette, clears the slot table, and walks the
// triangular probe sequence one slot at a time.
// ----------------------------------------------------------------------------
module piqh_probe_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_idle,
    input  logic             i_accept,
    input  piqh_pkg::t_pixel i_pixel,
    input  logic             i_palette_mode,
    output logic             o_res_valid,
    output piqh_pkg::t_result o_res,
    input  logic             i_res_take
);
    import piqh_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_PAL,
        S_CMP,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [SLOT_W-1:0]  r_clr, n_clr;
    logic [SLOT_W-1:0]  r_pos, n_pos;
    logic [PROBE_W-1:0] r_probe, n_probe;
    logic [PAL_W:0]     r_next, n_next;
    logic               r_err, n_err;
    logic               r_pend, n_pend;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_transp, n_transp;
    logic [INDEX_W-1:0] r_idx, n_idx;
    logic               r_new, n_new;

    t_slot              hash_mem [TABLE_SIZE];
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    t_slot              r_slot_q;
    logic [COLOR_W-1:0] r_pal_q;

    logic               hash_we;
    logic [SLOT_W-1:0]  hash_waddr;
    t_slot              hash_wdata;
    logic               pal_we;
    logic [PAL_W-1:0]   pal_waddr;
    logic [COLOR_W-1:0] pal_wdata;

    logic [PAL_W:0]     limit;
    logic [PROBE_W-1:0] probe_inc;

    assign limit     = i_palette_mode ? (PAL_W+1)'(LIMIT_LARGE) : (PAL_W+1)'(LIMIT_SMALL);
    assign probe_inc = r_probe + PROBE_W'(1);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_pos      = r_pos;
        n_probe    = r_probe;
        n_next     = r_next;
        n_err      = r_err;
        n_pend     = r_pend;
        n_color    = r_color;
        n_transp   = r_transp;
        n_idx      = r_idx;
        n_new      = r_new;
        hash_we    = 1'b0;
        hash_waddr = r_pos;
        hash_wdata = '0;
        pal_we     = 1'b0;
        pal_waddr  = r_next[PAL_W-1:0];
        pal_wdata  = r_color;

        case (r_state)
            S_CLEAR: begin
                // sweep the slot table, seed the transparent palette entry
                hash_we    = 1'b1;
                hash_waddr = r_clr;
                if (r_clr == '0) begin
                    pal_we    = 1'b1;
                    pal_waddr = '0;
                    pal_wdata = TRANSPARENT_COLOR;
                end
                n_clr = r_clr + SLOT_W'(1);
                if (r_clr == '1) begin
                    if (!r_pend) begin
                        n_state = S_IDLE;
                    end else if (r_transp) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SLOT;
                    end
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    n_color  = i_pixel.pixel_color;
                    n_transp = i_pixel.is_transparent;
                    n_pos    = home_slot(i_pixel.pixel_color);
                    n_probe  = '0;
                    n_idx    = '0;
                    n_new    = 1'b0;
                    n_pend   = 1'b1;
                    if (i_pixel.frame_start) begin
                        n_state = S_CLEAR;
                        n_clr   = '0;
                        n_next  = (PAL_W+1)'(1);
                        n_err   = 1'b0;
                    end else if (i_pixel.is_transparent) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SLOT;
                    end
                end
            end
            S_SLOT: begin
                n_state = S_PAL;
            end
            S_PAL: begin
                if (!r_slot_q.valid) begin
                    // empty slot: add the colour if the palette has room
                    if (r_next < limit) begin
                        hash_we          = 1'b1;
                        hash_wdata.valid = 1'b1;
                        hash_wdata.idx   = r_next[PAL_W-1:0];
                        pal_we           = 1'b1;
                        n_idx            = INDEX_W'(r_next);
                        n_new            = 1'b1;
                        n_next           = r_next + (PAL_W+1)'(1);
                    end else begin
                        n_err = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_pal_q == r_color) begin
                    n_idx   = INDEX_W'(r_slot_q.idx);
                    n_state = S_DONE;
                end else begin
                    // collision: advance to the next triangular offset
                    n_probe = probe_inc;
                    n_pos   = r_pos + probe_inc[SLOT_W-1:0];
                    if (probe_inc == PROBE_W'(TABLE_SIZE)) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SLOT;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_next   <= (PAL_W+1)'(1);
            r_err    <= 1'b0;
            r_pend   <= 1'b0;
            r_transp <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_next   <= n_next;
            r_err    <= n_err;
            r_pend   <= n_pend;
            r_transp <= n_transp;
        end
        r_pos   <= n_pos;
        r_probe <= n_probe;
        r_color <= n_color;
        r_idx   <= n_idx;
        r_new   <= n_new;
    end

    always_ff @(posedge i_clk) begin
        if (hash_we) begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        r_slot_q <= hash_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[pal_waddr] <= pal_wdata;
        end
        r_pal_q <= pal_mem[r_slot_q.idx];
    end

    assign o_idle                  = (r_state == S_IDLE);
    assign o_res_valid             = (r_state == S_DONE);
    assign o_res.palette_index     = r_idx;
    assign o_res.new_entry         = r_new;
    assign o_res.overflow          = r_err;
    assign o_res.probe_count       = r_probe;

`ifndef SYNTHESIS
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_idle |-> !o_res_valid)
        else $error("engine idle while a result is pending");

    a_next_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= (PAL_W+1)'(PALETTE_DEPTH))
        else $error("next palette index beyond palette depth");

    a_new_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_new) |-> (r_idx != '0) && !r_transp)
        else $error("new entry with index zero or on transparent pixel");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_idle && i_pixel.frame_start) |=> (r_state == S_CLEAR) && !r_err)
        else $error("frame start did not begin a clearing pass");
`endif

endmodule

// ===== hw/rtl/palette_indexer_quadratic_hash.sv =====
// ----------------------------------------------------------------------------
// palette_indexer_quadratic_hash: colour to palette index converter
// Maps 16-bit pixel colours to palette indices in first-seen order using a
// hash table with triangular (quadratic) probing.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  i_pix     in   valid/ready         pixel_color, is_transparent, frame_start
//  o_res     out  valid/ready         palette_index, new_entry, overflow, probe_count
//  i_cfg_*   in   write enable only   palette_mode (1 bit, reset 1)
//
//  A transparent pixel skips the table and goes straight to a result.
//  Other pixels run a slot read, a palette read and a compare for each
//  probed slot; an empty slot or a matching colour ends the search.
//  A frame_start pixel first runs a sweep over all 1024 table slots;
//  the same sweep runs right after reset, with i_pix.ready low throughout.
//  A stalled result waits in the output register while the next pixel is
//  already taken; the engine holds its own result until that register frees.
// ----------------------------------------------------------------------------
module palette_indexer_quadratic_hash (
    input  logic         i_clk,
    input  logic         i_rst_n,
    piqh_pixel_if.sink   i_pix,
    piqh_result_if.source o_res,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata
);
    import piqh_pkg::*;

    logic    r_palette_mode;
    logic    r_out_valid;
    t_result r_out;

    logic    eng_idle;
    logic    pix_xfer;
    logic    eng_res_valid;
    t_result eng_res;
    logic    out_load;
    t_pixel  pix;

    // pack the channel payload for the engine
    assign pix.pixel_color    = i_pix.pixel_color;
    assign pix.is_transparent = i_pix.is_transparent;
    assign pix.frame_start    = i_pix.frame_start;

    // take a pixel only while the sequencer waits for one
    assign i_pix.ready = eng_idle;
    assign pix_xfer    = i_pix.valid && eng_idle;

    // load the output register when it is empty or its result drains now
    assign out_load = eng_res_valid && (!r_out_valid || o_res.ready);

    piqh_probe_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .o_idle         (eng_idle),
        .i_accept       (pix_xfer),
        .i_pixel        (pix),
        .i_palette_mode (r_palette_mode),
        .o_res_valid    (eng_res_valid),
        .o_res          (eng_res),
        .i_res_take     (out_load)
    );

    // configuration register and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_mode <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_palette_mode <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (out_load) begin
            r_out <= eng_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.palette_index = r_out.palette_index;
    assign o_res.new_entry     = r_out.new_entry;
    assign o_res.overflow      = r_out.overflow;
    assign o_res.probe_count   = r_out.probe_count;

endmodule
